### design/isc_pkg.sv
// Shared types and constants for the image scale/crop resampler.
// Used by isc_front, isc_queue, isc_back and the top level; no dependencies.
package isc_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_INV_SCALE  = 3'd0;
    localparam logic [2:0] REG_CENTER_X   = 3'd1;
    localparam logic [2:0] REG_CENTER_Y   = 3'd2;
    localparam logic [2:0] REG_IN_WIDTH   = 3'd3;
    localparam logic [2:0] REG_IN_HEIGHT  = 3'd4;
    localparam logic [2:0] REG_OUT_WIDTH  = 3'd5;
    localparam logic [2:0] REG_OUT_HEIGHT = 3'd6;

    // Request kinds on the input channel.
    localparam logic KIND_STORE = 1'b0;
    localparam logic KIND_FETCH = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [23:0] INV_SCALE_RST = 24'd65536;
    localparam logic [8:0]  SIZE_RST      = 9'd256;

    // Request queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;
    localparam int QLW    = 3;

    // One classified request: a pixel write or a resolved fetch.
    typedef struct packed {
        logic        fetch;   // 1 for a fetch, 0 for a pixel write
        logic        hit;     // write lands in the store / source lies inside
        logic [8:0]  x;
        logic [8:0]  y;
        logic [31:0] pixel;
    } isc_entry_t;

    typedef struct packed {
        logic       valid;
        isc_entry_t entry;
    } isc_req_t;

endpackage

### design/isc_front.sv
// Front end: configuration registers, request intake and coordinate mapping.
// Depends on isc_pkg; feeds isc_queue.
module isc_front import isc_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [2:0]     cfg_index,
    input  logic [23:0]    cfg_data,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic           kind,
    input  logic [7:0]     col,
    input  logic [7:0]     row,
    input  logic [31:0]    pixel,
    input  logic [QLW-1:0] q_level,
    output isc_req_t       push
);

    localparam logic [12:0] MAXW = 13'(MAX_WIDTH);
    localparam logic [12:0] MAXH = 13'(MAX_HEIGHT);

    logic [23:0]        inv_scale_reg;
    logic signed [20:0] center_x_reg;
    logic signed [20:0] center_y_reg;
    logic [8:0]         in_width_reg;
    logic [8:0]         in_height_reg;
    logic [8:0]         out_width_reg;
    logic [8:0]         out_height_reg;

    logic               a_valid_reg;
    logic               a_kind_reg;
    logic               a_store_ok_reg;
    logic [7:0]         a_col_reg;
    logic [7:0]         a_row_reg;
    logic [31:0]        a_pixel_reg;
    logic signed [34:0] a_prod_x_reg;
    logic signed [34:0] a_prod_y_reg;

    logic               accept;
    logic signed [9:0]  dx;
    logic signed [9:0]  dy;
    logic signed [24:0] scale_s;
    logic signed [34:0] prod_x_next;
    logic signed [34:0] prod_y_next;
    logic signed [35:0] sum_x;
    logic signed [35:0] sum_y;
    logic [17:0]        qx;
    logic [17:0]        qy;
    logic [8:0]         wi;
    logic [8:0]         hi;
    logic               in_x;
    logic               in_y;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_scale_reg  <= INV_SCALE_RST;
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            in_width_reg   <= SIZE_RST;
            in_height_reg  <= SIZE_RST;
            out_width_reg  <= SIZE_RST;
            out_height_reg <= SIZE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_INV_SCALE:  inv_scale_reg  <= cfg_data;
                REG_CENTER_X:   center_x_reg   <= cfg_data[20:0];
                REG_CENTER_Y:   center_y_reg   <= cfg_data[20:0];
                REG_IN_WIDTH:   in_width_reg   <= cfg_data[8:0];
                REG_IN_HEIGHT:  in_height_reg  <= cfg_data[8:0];
                REG_OUT_WIDTH:  out_width_reg  <= cfg_data[8:0];
                REG_OUT_HEIGHT: out_height_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Every request in stage A or in the queue holds a queue slot, so the
    // push out of stage A never finds the queue full.
    assign in_stall = (q_level + QLW'(a_valid_reg)) >= QLW'(QDEPTH);
    assign accept   = in_valid && !in_stall;

    // Stage A: 2*o - N and the scale product for each axis.
    assign dx          = $signed({1'b0, col, 1'b0}) - $signed({1'b0, out_width_reg});
    assign dy          = $signed({1'b0, row, 1'b0}) - $signed({1'b0, out_height_reg});
    assign scale_s     = $signed({1'b0, inv_scale_reg});
    assign prod_x_next = scale_s * dx;
    assign prod_y_next = scale_s * dy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_kind_reg     <= kind;
            a_col_reg      <= col;
            a_row_reg      <= row;
            a_pixel_reg    <= pixel;
            a_store_ok_reg <= ({5'b0, col} < MAXW) && ({5'b0, row} < MAXH);
            a_prod_x_reg   <= prod_x_next;
            a_prod_y_reg   <= prod_y_next;
        end
    end

    // Stage B: add centre and one half in Q.17, then truncate toward zero.
    // A sum in (-1, 0) truncates to zero, so only the sign and the integer
    // part of a non-negative sum matter.
    assign sum_x = {a_prod_x_reg[34], a_prod_x_reg}
                 + {{6{center_x_reg[20]}}, center_x_reg, 9'b0}
                 + 36'sd65536;
    assign sum_y = {a_prod_y_reg[34], a_prod_y_reg}
                 + {{6{center_y_reg[20]}}, center_y_reg, 9'b0}
                 + 36'sd65536;

    assign qx = sum_x[35] ? 18'd0 : sum_x[34:17];
    assign qy = sum_y[35] ? 18'd0 : sum_y[34:17];

    assign wi = ({4'b0, in_width_reg} > MAXW) ? MAXW[8:0] : in_width_reg;
    assign hi = ({4'b0, in_height_reg} > MAXH) ? MAXH[8:0] : in_height_reg;

    assign in_x = (sum_x > -36'sd131072) && ({9'b0, wi} > qx);
    assign in_y = (sum_y > -36'sd131072) && ({9'b0, hi} > qy);

    always_comb
    begin
        push.valid       = a_valid_reg;
        push.entry.fetch = (a_kind_reg == KIND_FETCH);
        push.entry.pixel = a_pixel_reg;
        if (a_kind_reg == KIND_FETCH)
        begin
            push.entry.hit = in_x && in_y;
            push.entry.x   = qx[8:0];
            push.entry.y   = qy[8:0];
        end
        else
        begin
            push.entry.hit = a_store_ok_reg;
            push.entry.x   = {1'b0, a_col_reg};
            push.entry.y   = {1'b0, a_row_reg};
        end
    end

endmodule

### design/isc_queue.sv
// Short request queue that decouples the front end from the pixel store.
// Depends on isc_pkg; sits between isc_front and isc_back.
module isc_queue import isc_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    input  isc_req_t       push,
    input  logic           pop,
    output isc_req_t       head,
    output logic [QLW-1:0] level
);

    isc_entry_t     slot_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QLW-1:0] level_reg;
    logic [QLW-1:0] level_next;

    always_comb
    begin
        level_next = level_reg;
        if (push.valid && !pop)
        begin
            level_next = level_reg + QLW'(1);
        end
        else if (!push.valid && pop)
        begin
            level_next = level_reg - QLW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            slot_reg[wr_ptr_reg] <= push.entry;
        end
    end

    assign head.valid = (level_reg != '0);
    assign head.entry = slot_reg[rd_ptr_reg];
    assign level      = level_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> level_reg != QLW'(QDEPTH))
        else $error("request pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> level_reg != '0)
        else $error("request popped from an empty queue");

endmodule

### design/isc_back.sv
// Back end: pixel store, fetch read stage and output register.
// Depends on isc_pkg; drains isc_queue.
module isc_back import isc_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  isc_req_t    head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] value,
    output logic        inside_res
);

    localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW        = $clog2(MEM_DEPTH);

    logic [31:0]   mem [MEM_DEPTH];
    logic [31:0]   rdata_reg;
    logic          r_valid_reg;
    logic          r_hit_reg;
    logic          out_valid_reg;
    logic [31:0]   out_value_reg;
    logic          out_inside_reg;
    logic          o_free;
    logic [AW-1:0] addr;
    logic          wr_en;
    logic          rd_en;

    // The read stage only advances into a free output register; requests
    // leave the queue only when the read stage can move.
    assign o_free = !out_valid_reg || !out_stall;
    assign pop    = head.valid && (!r_valid_reg || o_free);
    assign addr   = AW'(32'(head.entry.y) * 32'(MAX_WIDTH) + 32'(head.entry.x));
    assign wr_en  = pop && !head.entry.fetch && head.entry.hit;
    assign rd_en  = pop && head.entry.fetch;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= head.entry.pixel;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                r_valid_reg <= 1'b1;
            end
            else if (o_free)
            begin
                r_valid_reg <= 1'b0;
            end
            if (o_free)
            begin
                out_valid_reg <= r_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            r_hit_reg <= head.entry.hit;
        end
        if (o_free && r_valid_reg)
        begin
            out_value_reg  <= r_hit_reg ? rdata_reg : 32'd0;
            out_inside_reg <= r_hit_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign value      = out_value_reg;
    assign inside_res = out_inside_reg;

    // An outside fetch may read an entry that was never written, so only the
    // data of a hit is required to hold.
    a_read_held: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid_reg && !o_free |=> r_valid_reg && (!r_hit_reg || $stable(rdata_reg)))
        else $error("read data lost while the output was stalled");

    a_read_moves: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid_reg && o_free |=> out_valid_reg)
        else $error("fetch result dropped between read and output");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_inside_reg |-> out_value_reg == 32'd0)
        else $error("outside fetch returned a nonzero value");

endmodule

### design/image_scale_crop_resampler.sv
// Top level of the nearest-neighbor image scale/crop resampler.
// Depends on isc_pkg, isc_front, isc_queue and isc_back.
//
//   channel   direction  handshake              payload
//   cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//   in        in         in_valid / in_stall    kind, col, row, pixel
//   out       out        out_valid / out_stall  value, inside_res
//
// One request per cycle is sustained while out_stall is low; the pixel store takes one access per cycle.
// A fetch result passes the mapping stage, the queue, the read stage and the output register.
// Reset loads the register defaults; the pixel store is not cleared.
// in_stall rises when the mapping stage and the four-entry queue hold four requests.
// cfg_ready is always high; the user must write registers only while the block is idle; it is not checked.
module image_scale_crop_resampler import isc_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [7:0]  col,
    input  logic [7:0]  row,
    input  logic [31:0] pixel,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] value,
    output logic        inside_res
);

    isc_req_t       push;
    isc_req_t       head;
    logic           pop;
    logic [QLW-1:0] q_level;

    isc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .col       (col),
        .row       (row),
        .pixel     (pixel),
        .q_level   (q_level),
        .push      (push)
    );

    isc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .level (q_level)
    );

    isc_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value      (value),
        .inside_res (inside_res)
    );

endmodule

### verif/tb_top.sv
// Testbench for image_scale_crop_resampler: drives store and fetch requests, programs
// the scale, center and size registers, and checks every fetch result in order.
// Depends on isc_pkg and the RTL of the resampler only.
module tb_top import isc_pkg::*;;

    localparam int   FRAME_COLS     = 256;
    localparam int   FRAME_ROWS     = 256;
    localparam int   FRAME_WORDS    = FRAME_COLS * FRAME_ROWS;
    localparam int   RANDOM_ITEMS   = 950;
    localparam int   PHASE_ITEMS    = 80;
    localparam int   HOLD_CYCLES    = 300;
    localparam int   DRAIN_CYCLES   = 10;
    localparam int   WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [31:0] value;
        logic        in_image;
    } resampled_t;

    class pixel_scoreboard;
        logic [31:0]        frame [FRAME_WORDS];
        bit                 loaded [FRAME_WORDS];
        logic [23:0]        inv_scale;
        logic signed [20:0] center_x;
        logic signed [20:0] center_y;
        logic [8:0]         in_width;
        logic [8:0]         in_height;
        logic [8:0]         out_width;
        logic [8:0]         out_height;
        resampled_t         expected_pixels [$];
        int                 errors;

        function new();
            inv_scale  = INV_SCALE_RST;
            center_x   = '0;
            center_y   = '0;
            in_width   = SIZE_RST;
            in_height  = SIZE_RST;
            out_width  = SIZE_RST;
            out_height = SIZE_RST;
            errors     = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [23:0] data);
            case (idx)
                REG_INV_SCALE:  inv_scale  = data;
                REG_CENTER_X:   center_x   = data[20:0];
                REG_CENTER_Y:   center_y   = data[20:0];
                REG_IN_WIDTH:   in_width   = data[8:0];
                REG_IN_HEIGHT:  in_height  = data[8:0];
                REG_OUT_WIDTH:  out_width  = data[8:0];
                REG_OUT_HEIGHT: out_height = data[8:0];
                default: ;
            endcase
        endfunction

        // The sum is exact in Q.17; truncation goes toward zero on both sides.
        function longint map_axis(logic [7:0] o, logic [8:0] n, logic signed [20:0] centre);
            longint d;
            longint s;
            d = 2 * longint'(o) - longint'(n);
            s = longint'(inv_scale) * d + longint'(centre) * 512 + 65536;
            if (s >= 0)
                return s >>> 17;
            return -((-s) >>> 17);
        endfunction

        function logic locate(logic [7:0] c, logic [7:0] r, output logic [15:0] addr);
            longint xs;
            longint ys;
            longint wi;
            longint hi;
            wi = in_width;
            hi = in_height;
            if (wi > FRAME_COLS)
                wi = FRAME_COLS;
            if (hi > FRAME_ROWS)
                hi = FRAME_ROWS;
            xs = map_axis(c, out_width, center_x);
            ys = map_axis(r, out_height, center_y);
            addr = {ys[7:0], xs[7:0]};
            return xs >= 0 && xs < wi && ys >= 0 && ys < hi;
        endfunction

        function void note_request(logic k, logic [7:0] c, logic [7:0] r, logic [31:0] p);
            resampled_t  res;
            logic [15:0] addr;
            if (k == KIND_STORE)
            begin
                frame[{r, c}]  = p;
                loaded[{r, c}] = 1'b1;
            end
            else
            begin
                res.in_image = locate(c, r, addr);
                res.value    = res.in_image ? frame[addr] : 32'd0;
                expected_pixels.push_back(res);
            end
        endfunction

        function void check_result(logic [31:0] v, logic ins);
            resampled_t exp_px;
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected result: value %h inside_res %b", v, ins);
                errors++;
                return;
            end
            exp_px = expected_pixels.pop_front();
            if (v !== exp_px.value)
            begin
                $error("value: expected %h, got %h", exp_px.value, v);
                errors++;
            end
            if (ins !== exp_px.in_image)
            begin
                $error("inside_res: expected %b, got %b", exp_px.in_image, ins);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_pixels.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        kind;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [31:0] pixel;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] value;
    logic        inside_res;

    pixel_scoreboard sb;
    int              requests_sent = 0;
    int              idle_cycles = 0;
    bit              calm = 1'b0;
    bit              hold_off = 1'b0;

    image_scale_crop_resampler #(
        .MAX_WIDTH  (FRAME_COLS),
        .MAX_HEIGHT (FRAME_ROWS)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .col        (col),
        .row        (row),
        .pixel      (pixel),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value      (value),
        .inside_res (inside_res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly back-to-back, with short gaps and now and then a long one.
    function automatic int pause_length();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_coord(logic [8:0] n);
        if (n == 0 || n > FRAME_COLS || $urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, n - 1));
    endfunction

    function automatic logic [8:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 9'($urandom_range(16, 256));
        if (r < 85)
            return 9'($urandom_range(1, 15));
        if (r < 90)
            return 9'd0;
        return 9'($urandom_range(257, 511));
    endfunction

    function automatic int pick_center(logic [8:0] n);
        int                 span;
        logic signed [20:0] wild;
        span = (n > FRAME_COLS) ? FRAME_COLS : n;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(0, span * 256);
        wild = 21'($urandom());
        return wild;
    endfunction

    task automatic issue_request(input logic k, input logic [7:0] c, input logic [7:0] r,
                                 input logic [31:0] p);
        int gap;
        @(negedge clk);
        in_valid <= 1'b1;
        kind     <= k;
        col      <= c;
        row      <= r;
        pixel    <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(k, c, r, p);
        requests_sent++;
        gap = pause_length();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // A fetch never lands on a never-written pixel: the source is stored first.
    task automatic fetch_pixel(input logic [7:0] c, input logic [7:0] r);
        logic [15:0] addr;
        if (sb.locate(c, r, addr) && !sb.loaded[addr])
            issue_request(KIND_STORE, addr[7:0], addr[15:8], $urandom());
        issue_request(KIND_FETCH, c, r, $urandom());
    endtask

    task automatic random_item();
        if ($urandom_range(0, 9) < 3)
            issue_request(KIND_STORE, pick_coord(sb.in_width), pick_coord(sb.in_height),
                          $urandom());
        else
            fetch_pixel(pick_coord(sb.out_width), pick_coord(sb.out_height));
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        // A store may still be in flight after the last result.
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_frame(input logic [23:0] scale, input int cx, input int cy,
                                 input logic [8:0] iw, input logic [8:0] ih,
                                 input logic [8:0] ow, input logic [8:0] oh,
                                 input bit scramble);
        drain();
        write_reg(REG_INV_SCALE, scale);
        write_reg(REG_CENTER_X, {scramble ? 3'($urandom()) : 3'd0, 21'(cx)});
        write_reg(REG_CENTER_Y, {scramble ? 3'($urandom()) : 3'd0, 21'(cy)});
        write_reg(REG_IN_WIDTH, {scramble ? 15'($urandom()) : 15'd0, iw});
        write_reg(REG_IN_HEIGHT, {scramble ? 15'($urandom()) : 15'd0, ih});
        write_reg(REG_OUT_WIDTH, {scramble ? 15'($urandom()) : 15'd0, ow});
        write_reg(REG_OUT_HEIGHT, {scramble ? 15'($urandom()) : 15'd0, oh});
    endtask

    task automatic random_frame();
        logic [8:0]  iw;
        logic [8:0]  ih;
        logic [23:0] scale;
        iw = pick_size();
        ih = pick_size();
        case ($urandom_range(0, 3))
            0:       scale = 24'($urandom_range(1, 24'hFFFFFF));
            1:       scale = 24'($urandom_range(24'h004000, 24'h040000));
            default: scale = 24'($urandom_range(24'h008000, 24'h018000));
        endcase
        program_frame(scale, pick_center(iw), pick_center(ih), iw, ih, pick_size(),
                      pick_size(), $urandom_range(0, 3) == 0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(value, inside_res);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Receiver: random stall gaps, plus one long hold-off that backs the block up.
    initial
    begin
        int stretch;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
                hold_off = 1'b0;
            end
            else
            begin
                stretch = pause_length();
                if (stretch == 0)
                    out_stall <= 1'b0;
                else
                begin
                    out_stall <= 1'b1;
                    repeat (stretch) @(negedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    initial
    begin
        int target;
        int phase;
        sb        = new();
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_INV_SCALE;
        cfg_data  = '0;
        in_valid  = 1'b0;
        kind      = KIND_STORE;
        col       = '0;
        row       = '0;
        pixel     = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Register defaults: the corner fetches fall outside and at the frame middle.
        fetch_pixel(8'd0, 8'd0);
        fetch_pixel(8'd255, 8'd255);

        // Unit scale centered on the frame, so output maps onto input one to one.
        program_frame(24'h010000, 128 << 8, 128 << 8, 9'd256, 9'd256, 9'd256, 9'd256, 1'b0);
        issue_request(KIND_STORE, 8'd0, 8'd0, 32'hFFFF_FFFF);
        issue_request(KIND_STORE, 8'd255, 8'd255, 32'h0000_0000);
        fetch_pixel(8'd0, 8'd0);
        fetch_pixel(8'd255, 8'd255);
        fetch_pixel(8'd255, 8'd0);

        // Zero scale with a center just below zero: everything truncates onto pixel zero.
        program_frame(24'd0, -192, -192, 9'd256, 9'd256, 9'd256, 9'd256, 1'b0);
        fetch_pixel(8'd7, 8'd200);
        fetch_pixel(8'd255, 8'd0);

        // Largest scale and the center extremes on a one-pixel image.
        program_frame(24'hFFFFFF, -1048576, 1048575, 9'd1, 9'd1, 9'd1, 9'd1, 1'b0);
        fetch_pixel(8'd0, 8'd0);
        fetch_pixel(8'd255, 8'd255);

        // Smallest scale, empty input image, output sizes past the store.
        program_frame(24'd1, 0, 0, 9'd0, 9'd0, 9'd511, 9'd511, 1'b0);
        fetch_pixel(8'd3, 8'd4);

        // Input sizes past the store clamp to it; fetches beyond the output size.
        program_frame(24'h010000, 40 << 8, 40 << 8, 9'd511, 9'd300, 9'd16, 9'd16, 1'b0);
        fetch_pixel(8'd215, 8'd0);
        fetch_pixel(8'd230, 8'd0);
        fetch_pixel(8'd255, 8'd255);

        // Half scale on a tiny image with a fractional center.
        program_frame(24'h008000, (2 << 8) | 8'h80, 1 << 8, 9'd4, 9'd3, 9'd8, 9'd6, 1'b0);
        fetch_pixel(8'd0, 8'd0);
        fetch_pixel(8'd7, 8'd5);
        fetch_pixel(8'd8, 8'd6);

        target = requests_sent + RANDOM_ITEMS;
        phase  = 0;
        while (requests_sent < target)
        begin
            random_frame();
            calm = (phase % 4 == 2);
            if (phase == 1)
                hold_off = 1'b1;
            repeat (PHASE_ITEMS) random_item();
            phase++;
        end
        calm = 1'b0;
        drain();

        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
